@@ sv/rmv_pkg.sv @@
package rmv_pkg;

    localparam int MAX_COUNT  = 65536;
    localparam int FRAC_BITS  = 16;

    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = $clog2(MAX_COUNT + 1);
    localparam int MAG_W      = SAMPLE_W + FRAC_BITS;
    localparam int MEAN_W     = MAG_W + 1;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int ADD_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W      = 63;
    localparam int STEP_W     = $clog2(SUM_W + 1);

    localparam int VAR_W      = 46;
    localparam int OUT_MEAN_W = 32;
    localparam int OUT_CNT_W  = 17;
    localparam int OUT_CNT_MAX = (1 << OUT_CNT_W) - 1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                update;
        logic                last;
        logic [CNT_W-1:0]    n;
        logic                ovf;
    } t_cmd;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [STEP_W-1:0] steps;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ sv/rmv_front.sv @@
module rmv_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [rmv_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                           i_last,
    input  logic                           i_full,
    output logic                           o_push,
    output rmv_pkg::t_cmd                  o_cmd
);
    import rmv_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic [CNT_W-1:0] n_count;
    logic             n_ovf;
    logic             room;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign room    = r_count < CNT_W'(MAX_COUNT);

    always_comb begin
        o_cmd.sample = i_sample;
        o_cmd.last   = i_last;
        o_cmd.update = room;
        o_cmd.n      = room ? r_count + 1'b1 : r_count;
        o_cmd.ovf    = r_ovf || !room;
        n_count      = r_count;
        n_ovf        = r_ovf;
        if (o_push) begin
            if (i_last) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = o_cmd.n;
                n_ovf   = o_cmd.ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_COUNT))
        else $error("set count beyond limit");
`endif

endmodule

@@ sv/rmv_queue.sv @@
module rmv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rmv_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output rmv_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import rmv_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("request popped from empty queue");
`endif

endmodule

@@ sv/rmv_div.sv @@
module rmv_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rmv_pkg::t_div_req i_req,
    output rmv_pkg::t_div_rsp o_rsp
);
    import rmv_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_sub;
    logic              ge;

    assign rem_sh  = {r_rem, r_q[SUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], ge};
            r_rem <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= i_req.steps;
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

@@ sv/rmv_back.sv @@
module rmv_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rmv_pkg::t_cmd                   i_cmd,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rmv_pkg::VAR_W-1:0]       o_variance,
    output logic signed [rmv_pkg::OUT_MEAN_W-1:0] o_mean,
    output logic [rmv_pkg::OUT_CNT_W-1:0]   o_sample_count,
    output logic                            o_overflow
);
    import rmv_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_MDIV = 4'd2;
    localparam logic [3:0] S_D2   = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_VST  = 4'd6;
    localparam logic [3:0] S_VDIV = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    function automatic logic [MAG_W-1:0] mag_of(input logic [MEAN_W-1:0] d);
        logic [MEAN_W-1:0] a;
        a = d[MEAN_W-1] ? (~d + 1'b1) : d;
        return a[MAG_W-1:0];
    endfunction

    function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_W-1:0] w;
        w = (CNT_W + OUT_CNT_W)'(c);
        if (w > (CNT_W + OUT_CNT_W)'(OUT_CNT_MAX)) begin
            return '1;
        end
        return w[OUT_CNT_W-1:0];
    endfunction

    logic [3:0]               r_state;
    logic [3:0]               n_state;
    t_cmd                     r_cmd;
    logic signed [MEAN_W-1:0] r_mean;
    logic signed [MEAN_W-1:0] n_mean;
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         n_sum;
    logic                     r_d1_neg;
    logic [MAG_W-1:0]         r_d1mag;
    logic [MAG_W-1:0]         r_d2mag;
    logic [PROD_W-1:0]        r_prod;
    logic [VAR_W-1:0]         r_var;
    logic                     r_out_valid;
    logic [VAR_W-1:0]         r_out_var;
    logic [OUT_MEAN_W-1:0]    r_out_mean;
    logic [OUT_CNT_W-1:0]     r_out_cnt;
    logic                     r_out_ovf;

    logic [MEAN_W-1:0]        x_fix;
    logic [MEAN_W-1:0]        d_cur;
    logic [MAG_W-1:0]         d_mag;
    logic [MEAN_W-1:0]        q_ext;
    logic [SUM_W:0]           sum_ext;
    logic                     out_load;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    rmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign x_fix    = {r_cmd.sample[SAMPLE_W-1], r_cmd.sample, {FRAC_BITS{1'b0}}};
    assign d_cur    = x_fix - r_mean;
    assign d_mag    = mag_of(d_cur);
    assign q_ext    = {1'b0, div_rsp.quotient[MAG_W-1:0]};
    assign sum_ext  = {1'b0, r_sum} + (SUM_W + 1)'(r_prod[PROD_W-1:FRAC_BITS]);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {d_mag, {(SUM_W - MAG_W){1'b0}}};
        div_req.steps    = STEP_W'(MAG_W);
        div_req.divisor  = r_cmd.n;
        if (r_state == S_PREP) begin
            div_req.start = 1'b1;
        end else if (r_state == S_VST) begin
            div_req.start    = 1'b1;
            div_req.dividend = r_sum;
            div_req.steps    = STEP_W'(SUM_W);
        end
    end

    always_comb begin
        n_state = r_state;
        n_mean  = r_mean;
        n_sum   = r_sum;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.update) begin
                        n_state = S_PREP;
                    end else if (i_cmd.last) begin
                        n_state = S_VST;
                    end
                end
            end
            S_PREP: begin
                n_state = S_MDIV;
            end
            S_MDIV: begin
                if (div_rsp.done) begin
                    n_mean  = r_d1_neg ? r_mean - q_ext : r_mean + q_ext;
                    n_state = S_D2;
                end
            end
            S_D2: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_sum   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                n_state = r_cmd.last ? S_VST : S_IDLE;
            end
            S_VST: begin
                n_state = S_VDIV;
            end
            S_VDIV: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_mean  = '0;
                    n_sum   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_PREP) begin
            r_d1_neg <= d_cur[MEAN_W-1];
            r_d1mag  <= d_mag;
        end
        if (r_state == S_D2) begin
            r_d2mag <= d_mag;
        end
        if (r_state == S_MUL) begin
            r_prod <= r_d1mag * r_d2mag;
        end
        if (r_state == S_VDIV && div_rsp.done) begin
            r_var <= (|div_rsp.quotient[SUM_W-1:VAR_W]) ? '1
                                                         : div_rsp.quotient[VAR_W-1:0];
        end
        if (out_load) begin
            r_out_var  <= r_var;
            r_out_mean <= OUT_MEAN_W'(r_mean);
            r_out_cnt  <= sat_count(r_cmd.n);
            r_out_ovf  <= r_cmd.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mean      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mean  <= n_mean;
            r_sum   <= n_sum;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_variance     = r_out_var;
    assign o_mean         = r_out_mean;
    assign o_sample_count = r_out_cnt;
    assign o_overflow     = r_out_ovf;

`ifndef SYNTHESIS
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MDIV) && !div_rsp.done |=> r_state == S_MDIV)
        else $error("mean update left before quotient");
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_MDIV) || (r_state == S_VDIV))
        else $error("quotient arrived with no one waiting");
`endif

endmodule

@@ sv/running_mean_variance.sv @@
// Running mean and population variance (Welford update) over sets of signed
// 16-bit samples; i_last closes a set and yields one result with variance and
// mean in fixed point with 16 fraction bits, the sample count and an overflow
// flag, then the state clears for the next set. Samples past 65536 in a set are
// dropped and flagged. An ordinary sample occupies the datapath while the
// 32-step restoring divider scales the mean update by the count; a closing
// sample adds the 63-step division of the deviation sum. A two-entry request
// queue sits between the input side and the datapath, and the result sits in
// an output register, but a long output stall still fills the queue and then
// stalls the input.
module running_mean_variance (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [rmv_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                  i_last,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [rmv_pkg::VAR_W-1:0]             o_variance,
    output logic signed [rmv_pkg::OUT_MEAN_W-1:0] o_mean,
    output logic [rmv_pkg::OUT_CNT_W-1:0]         o_sample_count,
    output logic                                  o_overflow
);
    import rmv_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    rmv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .i_last   (i_last),
        .i_full   (full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    rmv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    rmv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_variance     (o_variance),
        .o_mean         (o_mean),
        .o_sample_count (o_sample_count),
        .o_overflow     (o_overflow)
    );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import rmv_pkg::*;

    localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAR_MAX = (64'd1 << VAR_W) - 64'd1;
    localparam logic [63:0] CNT_MAX = (64'd1 << OUT_CNT_W) - 64'd1;
    localparam int RANDOM_REQUESTS = 1700;
    localparam int HOLD_CYCLES     = 2000;

    typedef struct packed {
        logic [VAR_W-1:0]      variance;
        logic [OUT_MEAN_W-1:0] mean;
        logic [OUT_CNT_W-1:0]  sample_count;
        logic                  overflow;
    } t_stats;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       typed;
        t_stats                     want;
    } t_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic signed [SAMPLE_W-1:0]   i_sample = '0;
    logic                         i_last = 1'b0;
    logic                         i_stall = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    logic [VAR_W-1:0]             o_variance;
    logic signed [OUT_MEAN_W-1:0] o_mean;
    logic [OUT_CNT_W-1:0]         o_sample_count;
    logic                         o_overflow;

    int     req_row = -1;
    int     burst_left = 0;
    bit     idle_en = 1'b1;
    bit     hold_off_req = 1'b0;
    int     errors = 0;
    int     n_requests = 0;
    int     n_results = 0;
    t_row   dir_rows[$];
    t_stats pending_stats[$];

    logic [OUT_CNT_W-1:0] acc_count = '0;
    longint               acc_mean = 0;
    logic [62:0]          acc_sq_dev = '0;
    logic                 acc_ovf = 1'b0;

    running_mean_variance uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_variance     (o_variance),
        .o_mean         (o_mean),
        .o_sample_count (o_sample_count),
        .o_overflow     (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic welford_update(input logic signed [SAMPLE_W-1:0] x, input logic is_last,
                                  output bit has_stats, output t_stats stats);
        longint       xf, d1, d2;
        logic [63:0]  n, m1, m2, q, inc, sum_ext, var64;
        logic [127:0] prod;
        has_stats = 1'b0;
        stats = '0;
        if (acc_count < MAX_COUNT) begin
            n = {47'd0, acc_count} + 64'd1;
            xf = longint'(x) <<< FRAC_BITS;
            d1 = xf - acc_mean;
            m1 = d1 < 0 ? -d1 : d1;
            q = m1 / n;
            acc_mean = d1 < 0 ? acc_mean - longint'(q) : acc_mean + longint'(q);
            d2 = xf - acc_mean;
            m2 = d2 < 0 ? -d2 : d2;
            prod = ({64'd0, m1} * {64'd0, m2}) >> FRAC_BITS;
            inc = prod > {64'd0, SUM_MAX} ? SUM_MAX : prod[63:0];
            sum_ext = {1'b0, acc_sq_dev} + inc;
            acc_sq_dev = sum_ext > SUM_MAX ? SUM_MAX[62:0] : sum_ext[62:0];
            acc_count = n[OUT_CNT_W-1:0];
        end else begin
            acc_ovf = 1'b1;
        end
        if (is_last) begin
            var64 = {1'b0, acc_sq_dev} / {47'd0, acc_count};
            stats.variance = var64 > VAR_MAX ? VAR_MAX[VAR_W-1:0] : var64[VAR_W-1:0];
            stats.mean = acc_mean[OUT_MEAN_W-1:0];
            stats.sample_count = {47'd0, acc_count} > CNT_MAX ? CNT_MAX[OUT_CNT_W-1:0]
                                                              : acc_count;
            stats.overflow = acc_ovf;
            has_stats = 1'b1;
            acc_count = '0;
            acc_mean = 0;
            acc_sq_dev = '0;
            acc_ovf = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h (result %0d)",
                 $realtime, what, got, want, n_results);
        errors++;
    endtask

    function automatic void add_row(input logic signed [SAMPLE_W-1:0] s, input logic l,
                                    input logic typed, input t_stats want);
        t_row r;
        r.sample = s;
        r.last = l;
        r.typed = typed;
        r.want = want;
        dir_rows.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        bit     has_stats;
        t_stats stats;
        t_stats want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                welford_update(i_sample, i_last, has_stats, stats);
                if (has_stats) begin
                    if (req_row >= 0 && dir_rows[req_row].typed)
                        pending_stats.push_back(dir_rows[req_row].want);
                    else
                        pending_stats.push_back(stats);
                end
            end
            if (o_valid && !i_stall) begin
                n_results++;
                if (pending_stats.size() == 0) begin
                    report_mismatch("unexpected result variance", 64'(o_variance), 64'd0);
                end else begin
                    want = pending_stats.pop_front();
                    if (o_variance !== want.variance)
                        report_mismatch("variance", 64'(o_variance), 64'(want.variance));
                    if (o_mean !== want.mean)
                        report_mismatch("mean", 64'(o_mean), 64'(want.mean));
                    if (o_sample_count !== want.sample_count)
                        report_mismatch("sample_count", 64'(o_sample_count),
                                        64'(want.sample_count));
                    if (o_overflow !== want.overflow)
                        report_mismatch("overflow", 64'(o_overflow), 64'(want.overflow));
                end
            end
        end
    end

    task automatic offer(input logic signed [SAMPLE_W-1:0] s, input logic l, input int row);
        int gap;
        if (idle_en && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        i_valid <= 1'b1;
        i_sample <= s;
        i_last <= l;
        req_row <= row;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        n_requests++;
    endtask

    initial begin
        int phase_len;
        int mode;
        int c;
        wait (i_rst_n);
        forever begin
            phase_len = $urandom_range(10, 150);
            mode = $urandom_range(0, 3);
            for (c = 0; c < phase_len; c++) begin
                @(posedge i_clk);
                if (hold_off_req) begin
                    i_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_off_req = 1'b0;
                    i_stall <= 1'b0;
                end else begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 3) == 0);
                        2: i_stall <= ($urandom_range(0, 3) != 0);
                        default: i_stall <= ~i_stall;
                    endcase
                end
            end
        end
    end

    initial begin
        #250_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int i;
        int k;
        int len;
        int kind;
        int n_random;
        bit hold_armed;
        logic signed [SAMPLE_W-1:0] s;
        logic signed [SAMPLE_W-1:0] base;

        add_row(16'sd0,      1'b1, 1'b1, '{46'd0, 32'h0000_0000, 17'd1, 1'b0});
        add_row(16'sd32767,  1'b1, 1'b1, '{46'd0, 32'h7FFF_0000, 17'd1, 1'b0});
        add_row(-16'sd32768, 1'b1, 1'b1, '{46'd0, 32'h8000_0000, 17'd1, 1'b0});
        add_row(16'sd32767,  1'b0, 1'b0, '0);
        add_row(-16'sd32768, 1'b1, 1'b1, '{46'h3FFF_8000_4000, 32'hFFFF_8000, 17'd2, 1'b0});
        add_row(16'sd1,      1'b0, 1'b0, '0);
        add_row(16'sd2,      1'b1, 1'b1, '{46'd16384, 32'h0001_8000, 17'd2, 1'b0});
        add_row(16'sd1000,   1'b0, 1'b0, '0);
        add_row(16'sd1000,   1'b0, 1'b0, '0);
        add_row(16'sd1000,   1'b0, 1'b0, '0);
        add_row(16'sd1000,   1'b1, 1'b1, '{46'd0, 32'h03E8_0000, 17'd4, 1'b0});
        add_row(-16'sd32768, 1'b0, 1'b0, '0);
        add_row(16'sd32767,  1'b0, 1'b0, '0);
        add_row(-16'sd32768, 1'b0, 1'b0, '0);
        add_row(16'sd32767,  1'b1, 1'b0, '0);
        add_row(-16'sd1,     1'b0, 1'b0, '0);
        add_row(16'sd0,      1'b0, 1'b0, '0);
        add_row(-16'sd1,     1'b0, 1'b0, '0);
        add_row(16'sd3,      1'b1, 1'b0, '0);
        add_row(-16'sd7,     1'b0, 1'b0, '0);
        add_row(16'sd12345,  1'b0, 1'b0, '0);
        add_row(-16'sd300,   1'b0, 1'b0, '0);
        add_row(16'sd5,      1'b1, 1'b0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < dir_rows.size(); i++)
            offer(dir_rows[i].sample, dir_rows[i].last, i);

        n_random = 0;
        hold_armed = 1'b0;
        while (n_random < RANDOM_REQUESTS) begin
            k = $urandom_range(0, 9);
            if (k < 7)
                len = $urandom_range(1, 8);
            else if (k < 9)
                len = $urandom_range(9, 32);
            else
                len = $urandom_range(33, 80);
            kind = $urandom_range(0, 3);
            base = $urandom_range(0, 1) ? 16'sd32700 : -16'sd32700;
            for (k = 0; k < len; k++) begin
                case (kind)
                    0: s = SAMPLE_W'($urandom);
                    1: s = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
                    2: begin
                        case ($urandom_range(0, 3))
                            0: s = 16'sh8000;
                            1: s = 16'sh7FFF;
                            2: s = 16'sh8001;
                            default: s = 16'sh0000;
                        endcase
                    end
                    default: s = base + SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
                endcase
                if (!hold_armed && n_random >= 150) begin
                    hold_armed = 1'b1;
                    hold_off_req = 1'b1;
                end
                offer(s, k == len - 1, -1);
                n_random++;
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Run covered %0d requests and %0d checked results: extreme samples,",
                 n_requests, n_results);
        $display("hand-checked sets, and random sets under sender gaps, receiver stalls and a long hold-off.");
        if (errors == 0 && pending_stats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
